@@ sv/phcc_pkg.sv @@
// Types, constants and the CRC-16/X.25 byte update for the packet header check.
`default_nettype none

package phcc_pkg;

  localparam int unsigned HdrLen      = 11;
  localparam int unsigned HdrCrcSpan  = 7;
  localparam int unsigned CountW      = 17;
  localparam int unsigned TotalW      = CountW + 1;
  localparam int unsigned TdataOutW   = 72;

  localparam logic [15:0]       CrcInit     = 16'hFFFF;
  localparam logic [15:0]       CrcPolyRefl = 16'h8408;
  localparam logic [CountW-1:0] CountMax    = {CountW{1'b1}};

  typedef enum logic [2:0] {
    ST_OK          = 3'd0,
    ST_TOO_SHORT   = 3'd1,
    ST_HDR_CRC_BAD = 3'd2,
    ST_TRUNCATED   = 3'd3,
    ST_PAY_CRC_BAD = 3'd4
  } status_e;

  typedef struct packed {
    logic        payload_valid;
    logic [7:0]  payload_byte;
    logic        verdict_valid;
    status_e     status;
    logic [7:0]  packet_type;
    logic [31:0] sequence_number;
    logic [15:0] payload_length;
  } result_t;

  function automatic logic [15:0] crc_x25_step(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CrcPolyRefl;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

`default_nettype wire

@@ sv/phcc_parse.sv @@
// Header parser, CRC accumulators and verdict logic for one datagram byte.
`default_nettype none

module phcc_parse
  import phcc_pkg::*;
(
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    step_i,
  input  wire logic [7:0] data_byte_i,
  input  wire logic    last_i,
  output result_t      result_o
);

  logic [CountW-1:0] count_q, count_d;
  logic [15:0]       hcrc_q, hcrc_d;
  logic [15:0]       pcrc_q, pcrc_d;
  logic [7:0]        type_q, type_d;
  logic [31:0]       seq_q, seq_d;
  logic [15:0]       len_q, len_d;
  logic [15:0]       rxh_q, rxh_d;
  logic [15:0]       rxp_q, rxp_d;

  logic [TotalW-1:0] total;
  logic [TotalW-1:0] idx_w;
  logic [TotalW-1:0] frame_end;
  logic [TotalW-1:0] frame_end_next;
  logic              in_payload;
  logic              hdr_good_now;
  logic              hdr_good_next;
  result_t           res;

  always_comb begin
    idx_w        = {1'b0, count_q};
    total        = idx_w + TotalW'(1);
    frame_end    = TotalW'(HdrLen) + {{(TotalW-16){1'b0}}, len_q};
    in_payload   = (idx_w >= TotalW'(HdrLen)) && (idx_w < frame_end);
    hdr_good_now = ((hcrc_q ^ 16'hFFFF) == rxh_q);

    hcrc_d = hcrc_q;
    pcrc_d = pcrc_q;
    type_d = type_q;
    seq_d  = seq_q;
    len_d  = len_q;
    rxh_d  = rxh_q;
    rxp_d  = rxp_q;

    if (idx_w < TotalW'(HdrCrcSpan)) begin
      hcrc_d = crc_x25_step(hcrc_q, data_byte_i);
    end

    if (idx_w == TotalW'(0)) begin
      type_d = data_byte_i;
    end else if (idx_w <= TotalW'(4)) begin
      seq_d = {seq_q[23:0], data_byte_i};
    end else if (idx_w <= TotalW'(6)) begin
      len_d = {len_q[7:0], data_byte_i};
    end else if (idx_w <= TotalW'(8)) begin
      rxh_d = {rxh_q[7:0], data_byte_i};
    end else if (idx_w <= TotalW'(10)) begin
      rxp_d = {rxp_q[7:0], data_byte_i};
    end else if (in_payload) begin
      pcrc_d = crc_x25_step(pcrc_q, data_byte_i);
    end

    count_d = (total > {1'b0, CountMax}) ? CountMax : total[CountW-1:0];

    hdr_good_next  = ((hcrc_d ^ 16'hFFFF) == rxh_d);
    frame_end_next = TotalW'(HdrLen) + {{(TotalW-16){1'b0}}, len_d};

    res = '0;
    res.status = ST_OK;
    if (in_payload && hdr_good_now) begin
      res.payload_valid = 1'b1;
      res.payload_byte  = data_byte_i;
    end
    if (last_i) begin
      res.verdict_valid = 1'b1;
      if (total < TotalW'(HdrLen)) begin
        res.status = ST_TOO_SHORT;
      end else begin
        res.packet_type     = type_d;
        res.sequence_number = seq_d;
        res.payload_length  = len_d;
        if (!hdr_good_next) begin
          res.status = ST_HDR_CRC_BAD;
        end else if (total < frame_end_next) begin
          res.status = ST_TRUNCATED;
        end else if ((pcrc_d ^ 16'hFFFF) != rxp_d) begin
          res.status = ST_PAY_CRC_BAD;
        end else begin
          res.status = ST_OK;
        end
      end
    end
  end

  assign result_o = res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      hcrc_q  <= CrcInit;
      pcrc_q  <= CrcInit;
      type_q  <= '0;
      seq_q   <= '0;
      len_q   <= '0;
      rxh_q   <= '0;
      rxp_q   <= '0;
    end else if (step_i) begin
      if (last_i) begin
        count_q <= '0;
        hcrc_q  <= CrcInit;
        pcrc_q  <= CrcInit;
        type_q  <= '0;
        seq_q   <= '0;
        len_q   <= '0;
        rxh_q   <= '0;
        rxp_q   <= '0;
      end else begin
        count_q <= count_d;
        hcrc_q  <= hcrc_d;
        pcrc_q  <= pcrc_d;
        type_q  <= type_d;
        seq_q   <= seq_d;
        len_q   <= len_d;
        rxh_q   <= rxh_d;
        rxp_q   <= rxp_d;
      end
    end
  end

endmodule

`default_nettype wire

@@ sv/phcc_out_reg.sv @@
// Result register holding one finished result until the downstream side takes it.
`default_nettype none

module phcc_out_reg
  import phcc_pkg::*;
(
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    load_i,
  input  wire result_t result_i,
  input  wire logic    ready_i,
  output logic         can_load_o,
  output logic         valid_o,
  output result_t      result_o
);

  logic    valid_q, valid_d;
  result_t result_q;

  assign can_load_o = !valid_q || ready_i;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      result_q <= result_i;
    end
  end

  assign valid_o  = valid_q;
  assign result_o = result_q;

endmodule

`default_nettype wire

@@ sv/packet_header_crc_check_core.sv @@
// Top level of the datagram header and payload CRC-16/X.25 checker.
// A request accepted into the input register moves on into the result register,
// from which the downstream side takes it. Throughput: one byte per cycle while
// the result side is not stalled; the input register frees in the same cycle that
// its byte moves into the result register, so back-to-back requests flow.
// Reset clears the input and result valid flags, the byte counter and the captured
// header fields, and sets both CRC accumulators to all ones.
`default_nettype none

module packet_header_crc_check_core
  import phcc_pkg::*;
(
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 s_axis_tvalid,
  output logic                      s_axis_tready,
  input  wire logic [7:0]           s_axis_tdata,   // [7:0] data_byte
  input  wire logic                 s_axis_tlast,
  output logic                      m_axis_tvalid,
  input  wire logic                 m_axis_tready,
  // [7:0] payload_byte, [10:8] status, [18:11] packet_type,
  // [50:19] sequence_number, [66:51] payload_length, [71:67] zero
  output logic [TdataOutW-1:0]      m_axis_tdata,
  output logic [1:0]                m_axis_tuser    // [0] payload_valid, [1] verdict_valid
);

  logic       in_valid_q, in_valid_d;
  logic [7:0] in_byte_q;
  logic       in_last_q;
  logic       accept;
  logic       advance;
  logic       can_load;
  result_t    res;
  result_t    out_res;

  assign advance       = in_valid_q && can_load;
  assign s_axis_tready = !in_valid_q || advance;
  assign accept        = s_axis_tvalid && s_axis_tready;

  always_comb begin
    in_valid_d = in_valid_q;
    if (accept) begin
      in_valid_d = 1'b1;
    end else if (advance) begin
      in_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      in_byte_q <= s_axis_tdata;
      in_last_q <= s_axis_tlast;
    end
  end

  phcc_parse u_parse (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (advance),
    .data_byte_i (in_byte_q),
    .last_i      (in_last_q),
    .result_o    (res)
  );

  phcc_out_reg u_out (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .load_i     (advance),
    .result_i   (res),
    .ready_i    (m_axis_tready),
    .can_load_o (can_load),
    .valid_o    (m_axis_tvalid),
    .result_o   (out_res)
  );

  assign m_axis_tdata = {5'b00000, out_res.payload_length, out_res.sequence_number,
                         out_res.packet_type, out_res.status, out_res.payload_byte};
  assign m_axis_tuser = {out_res.verdict_valid, out_res.payload_valid};

endmodule

`default_nettype wire

@@ sv/phcc_checker.sv @@
// Port-level checks on the result stream of the packet header checker.
`default_nettype none

module phcc_checker
  import phcc_pkg::*;
(
  input wire logic                 clk_i,
  input wire logic                 rst_ni,
  input wire logic                 m_axis_tvalid,
  input wire logic                 m_axis_tready,
  input wire logic [TdataOutW-1:0] m_axis_tdata,
  input wire logic [1:0]           m_axis_tuser
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("Stalled result request changed.");

  a_no_verdict_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser[1] |-> m_axis_tdata[TdataOutW-1:8] == '0)
    else $error("Verdict fields set without a verdict.");

  a_no_payload_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tdata[7:0] == 8'h00)
    else $error("Payload byte set without a payload request.");

  a_too_short_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[1] && (m_axis_tdata[10:8] == ST_TOO_SHORT)
      |-> m_axis_tdata[TdataOutW-1:11] == '0)
    else $error("Header fields reported for a short datagram.");

  a_status_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !(m_axis_tdata[10] && (m_axis_tdata[9:8] != 2'b00)))
    else $error("Status code out of range.");

endmodule

bind packet_header_crc_check_core phcc_checker u_phcc_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire
